### hdl/jsbw_pkg.sv
package jsbw_pkg;

    typedef enum logic [2:0] {
        OP_AND = 3'd0,
        OP_OR  = 3'd1,
        OP_XOR = 3'd2,
        OP_NOT = 3'd3,
        OP_SHL = 3'd4,
        OP_SAR = 3'd5,
        OP_SHR = 3'd6
    } op_t;

    localparam int unsigned EXP_BIAS = 1023;
    localparam int unsigned FRAC_W   = 52;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] a;
        logic [31:0] b;
    } s1_t;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic        zero;
        logic [32:0] ival;
    } s2_t;

    // Convert a double bit pattern to its low 32 integer bits (truncated, modulo 2^32).
    function automatic logic [31:0] dbl_to_u32(input logic [63:0] bits);
        logic [10:0] expo;
        logic [52:0] mant;
        logic [84:0] wide;
        logic [31:0] low;
        expo = bits[62:52];
        mant = {1'b1, bits[51:0]};
        low  = '0;
        if (expo != 11'h7ff && expo >= 11'(EXP_BIAS) && expo < 11'(EXP_BIAS + 84)) begin
            // Bit 52 of mant has weight 2^(expo-1023); place it and take the integer part.
            wide = {32'd0, mant} << (expo - 11'(EXP_BIAS));
            low  = wide[83:52];
            if (bits[63])
                low = 32'd0 - low;
        end
        return low;
    endfunction

endpackage

### hdl/jsbw_if.sv
interface jsbw_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [63:0] left_bits;
    logic [63:0] right_bits;
    modport source (output valid, mode, left_bits, right_bits, input ready);
    modport sink   (input valid, mode, left_bits, right_bits, output ready);
endinterface

interface jsbw_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        result_bits;
    logic signed [32:0] result_integer;
    modport source (output valid, result_bits, result_integer, input ready);
    modport sink   (input valid, result_bits, result_integer, output ready);
endinterface

### hdl/js_int32_bitwise_unit.sv
// One item per cycle while the output is not stalled; the operand conversion,
// the logic/shift stage and the double encoding each take one register stage.
// A stall holds every stage in place; nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
module js_int32_bitwise_unit (
    input  logic        clk,
    input  logic        rst_n,
    jsbw_in_if.sink     in_ch,
    jsbw_out_if.source  out_ch
);

    logic           v1_reg, v2_reg, v3_reg;
    jsbw_pkg::s1_t  s1_reg, s1_next;
    jsbw_pkg::s2_t  s2_reg, s2_next;
    logic [63:0]    rb_reg, rb_next;
    logic [32:0]    ri_reg;
    logic           en1, en2, en3;

    assign en3 = !v3_reg || out_ch.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ch.ready = en1;

    always_comb
    begin
        s1_next.mode = in_ch.mode;
        s1_next.a    = jsbw_pkg::dbl_to_u32(in_ch.left_bits);
        s1_next.b    = jsbw_pkg::dbl_to_u32(in_ch.right_bits);
    end

    always_comb
    begin
        logic [31:0] r;
        logic [4:0]  c;
        logic        uns;
        c   = s1_reg.b[4:0];
        uns = 1'b0;
        case (s1_reg.mode)
            jsbw_pkg::OP_AND: r = s1_reg.a & s1_reg.b;
            jsbw_pkg::OP_OR:  r = s1_reg.a | s1_reg.b;
            jsbw_pkg::OP_XOR: r = s1_reg.a ^ s1_reg.b;
            jsbw_pkg::OP_NOT: r = ~s1_reg.a;
            jsbw_pkg::OP_SHL: r = s1_reg.a << c;
            jsbw_pkg::OP_SAR: r = 32'($signed(s1_reg.a) >>> c);
            jsbw_pkg::OP_SHR:
            begin
                r   = s1_reg.a >> c;
                uns = 1'b1;
            end
            default: r = '0;
        endcase
        s2_next.ival = uns ? {1'b0, r} : {r[31], r};
        s2_next.neg  = !uns && r[31];
        s2_next.mag  = s2_next.neg ? 32'd0 - r : r;
        s2_next.zero = (r == 32'd0);
    end

    always_comb
    begin
        logic [4:0]  p;
        logic [31:0] norm;
        p = '0;
        for (int i = 0; i < 32; i++)
            if (s2_reg.mag[i])
                p = 5'(i);
        norm = s2_reg.mag << (5'd31 - p);
        if (s2_reg.zero)
            rb_next = '0;
        else
            rb_next = {s2_reg.neg, 11'(jsbw_pkg::EXP_BIAS) + {6'd0, p},
                       norm[30:0], 21'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_ch.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3)
        begin
            rb_reg <= rb_next;
            ri_reg <= s2_reg.ival;
        end
    end

    assign out_ch.valid          = v3_reg;
    assign out_ch.result_bits    = rb_reg;
    assign out_ch.result_integer = $signed(ri_reg);

endmodule

### hdl/jsbw_checker.sv
module jsbw_props (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [63:0]        result_bits,
    input logic signed [32:0] result_integer
);

    // A waiting result must hold steady until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bits))
        else $error("result changed while stalled");

    // Zero integer comes out as +0.0 and vice versa.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_integer == 33'sd0) == (result_bits == 64'd0)))
        else $error("zero encoding mismatch");

    // Sign of the double follows the sign of the integer.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_bits[63] == result_integer[32]))
        else $error("sign mismatch");

    // When the output is free, the block takes input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("stalled with empty output");

endmodule

bind js_int32_bitwise_unit jsbw_props u_jsbw_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .result_bits    (out_ch.result_bits),
    .result_integer (out_ch.result_integer)
);

### tb/jsbw_checker.sv
module jsbw_checker (
    input  logic       clk,
    input  logic       rst_n,
    jsbw_in_if         in_ch,
    jsbw_out_if        out_ch,
    output int         mismatches,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0]        bits;
        logic signed [32:0] ival;
    } bw_result_t;

    bw_result_t expected_q[$];

    // Truncate toward zero and reduce modulo 2^32.
    function automatic logic [31:0] to_uint32(input logic [63:0] d);
        int          e;
        logic [52:0] m;
        logic [31:0] r;
        e = int'(d[62:52]);
        m = {1'b1, d[51:0]};
        if (e == 2047 || e < 1023)
            return 32'd0;
        e = e - 1075;
        if (e >= 32)
            return 32'd0;
        if (e >= 0)
            r = 32'(m << e);
        else
            r = 32'(m >> (-e));
        if (d[63])
            r = -r;
        return r;
    endfunction

    function automatic logic [63:0] int_to_double(input longint v);
        logic [63:0] mag;
        logic        s;
        int          p;
        if (v == 0)
            return 64'd0;
        s = v < 0;
        mag = s ? 64'(-v) : 64'(v);
        p = 0;
        while (p < 63 && (mag >> (p + 1)) != 0)
            p++;
        return {s, 11'(1023 + p), 52'((mag << (52 - p)))};
    endfunction

    function automatic bw_result_t compute_bitwise(input logic [2:0] mode,
                                                   input logic [63:0] lb,
                                                   input logic [63:0] rb);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        longint      v;
        bw_result_t  res;
        a = to_uint32(lb);
        b = to_uint32(rb);
        r = 32'd0;
        case (mode)
            jsbw_pkg::OP_AND: r = a & b;
            jsbw_pkg::OP_OR:  r = a | b;
            jsbw_pkg::OP_XOR: r = a ^ b;
            jsbw_pkg::OP_NOT: r = ~a;
            jsbw_pkg::OP_SHL: r = a << b[4:0];
            jsbw_pkg::OP_SAR: r = 32'($signed(a) >>> b[4:0]);
            jsbw_pkg::OP_SHR: r = a >> b[4:0];
            default: r = 32'd0;
        endcase
        if (mode == jsbw_pkg::OP_SHR)
            v = longint'({32'd0, r});
        else
            v = longint'($signed(r));
        res.bits = int_to_double(v);
        res.ival = 33'(v);
        return res;
    endfunction

    assign pending = expected_q.size();

    initial mismatches = 0;

    always @(posedge clk)
    begin
        bw_result_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_q.push_back(compute_bitwise(in_ch.mode, in_ch.left_bits,
                                                 in_ch.right_bits));
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item bits=%h int=%0d",
                             out_ch.result_bits, out_ch.result_integer);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.bits !== out_ch.result_bits || want.ival !== out_ch.result_integer)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp bits=%h int=%0d got bits=%h int=%0d",
                                 want.bits, want.ival, out_ch.result_bits,
                                 out_ch.result_integer);
                end
            end
        end
    end
endmodule

### tb/js_int32_bitwise_unit_tb.sv
module js_int32_bitwise_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   pending;
    bit   hold_on = 1'b0;
    bit   calm = 1'b0;

    jsbw_in_if  in_ch();
    jsbw_out_if out_ch();

    js_int32_bitwise_unit DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
    jsbw_checker u_checker (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                            .mismatches(mismatches), .pending(pending));

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.left_bits = '0;
        in_ch.right_bits = '0;
        out_ch.ready = 1'b0;
    end

    // A double with a chosen exponent and random other bits; mostly in the
    // range where the integer conversion is not trivially zero.
    function automatic logic [63:0] random_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    ;
            2:       d[62:52] = 11'(1023 + $urandom_range(84, 1023));
            3:       d[62:52] = 11'($urandom_range(1000, 1022));
            default: d[62:52] = 11'(1023 + $urandom_range(0, 90));
        endcase
        return d;
    endfunction

    task automatic send_item(input logic [2:0] mode, input logic [63:0] lb,
                             input logic [63:0] rb);
        while (!calm && $urandom_range(0, 99) < 6)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.left_bits <= lb;
        in_ch.right_bits <= rb;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_on)
            begin
                out_ch.ready <= 1'b0;
                for (n = 0; n < 60; n++)
                    @(posedge clk);
                hold_on = 1'b0;
            end
            out_ch.ready <= calm || $urandom_range(0, 99) >= 6;
        end
    end

    initial
    begin
        logic [63:0] corner[12];
        logic [2:0]  op;
        int          i;
        int          w;
        corner = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
                   64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
                   64'h3fef_ffff_ffff_ffff, 64'h41df_ffff_ffc0_0000,
                   64'hc1e0_0000_0000_0000, 64'h41ef_ffff_ffe0_0000,
                   64'h4530_0000_0000_0001, 64'h44ff_ffff_ffff_ffff,
                   64'hc3e0_0000_0000_0001};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < 12; i++)
            send_item(3'(i % 8), corner[i], corner[11 - i]);
        send_item(jsbw_pkg::OP_SHL, 64'h3ff0_0000_0000_0000, 64'h403f_0000_0000_0000);
        send_item(jsbw_pkg::OP_SAR, 64'hc1e0_0000_0000_0000, 64'h4040_8000_0000_0000);
        send_item(jsbw_pkg::OP_SHR, 64'hbff0_0000_0000_0000, 64'h0);
        send_item(3'd7, 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000);
        for (i = 0; i < 1300; i++)
        begin
            if (i == 300)
                hold_on = 1'b1;
            calm = (i >= 600 && i < 800);
            op = 3'($urandom_range(0, 7));
            send_item(op, random_double(), random_double());
        end
        in_ch.valid <= 1'b0;
        w = 0;
        while (pending != 0 && w < 100000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule
